// File: rtl/local_sequence_alignment_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the local sequence alignment unit
// Short forms of the concurrent checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef LOCAL_SEQUENCE_ALIGNMENT_UNIT_MACROS_SVH
`define LOCAL_SEQUENCE_ALIGNMENT_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define LSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared constants and types of the local sequence alignment unit.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam logic [7:0]  GAP_SYM     = 8'd45;

  // input selector codes
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // traceback directions
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_DIAG = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;
  localparam logic [1:0] DIR_LEFT = 2'd3;

  // register byte addresses
  localparam int unsigned ADDR_W = 4;
  localparam logic [ADDR_W-1:0] REG_MATCH    = 4'h0;
  localparam logic [ADDR_W-1:0] REG_MISMATCH = 4'h4;
  localparam logic [ADDR_W-1:0] REG_GAP      = 4'h8;

  localparam logic [3:0] MATCH_RST    = 4'd1;
  localparam logic [4:0] MISMATCH_RST = 5'h1F;
  localparam logic [4:0] GAP_RST      = 5'h1F;

  // result kinds
  localparam logic KIND_SUM = 1'b0;
  localparam logic KIND_COL = 1'b1;

  localparam int unsigned OUT_W = 72;

  typedef struct packed {
    logic v;
    logic first;
  } lsa_ctl_t;

endpackage

// File: rtl/lsa_cell.sv
// ----------------------------------------------------------------------------
// lsa_cell
// One row of the score matrix: holds a first-sequence symbol, scores each
// passing column, records its traceback direction and its row maximum.
// ----------------------------------------------------------------------------
module lsa_cell #(
  parameter int unsigned MAX_LEN  = lsa_pkg::MAX_LEN_DEF,
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned SW       = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [3:0]                         match_gain_i,
  input  logic [4:0]                         mismatch_gain_i,
  input  logic [4:0]                         gap_gain_i,
  input  logic                               ld_en_i,
  input  logic [$clog2(MAX_LEN)-1:0]         ld_idx_i,
  input  logic [7:0]                         ld_sym_i,
  input  lsa_pkg::lsa_ctl_t                  ctl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       col_i,
  input  logic [7:0]                         b_i,
  input  logic signed [SW-1:0]               h_i,
  output lsa_pkg::lsa_ctl_t                  ctl_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       col_o,
  output logic [7:0]                         b_o,
  output logic signed [SW-1:0]               h_o,
  input  logic                               clr_best_i,
  output logic [SW-1:0]                      best_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       best_col_o,
  input  logic [$clog2(MAX_LEN)-1:0]         tb_addr_i,
  output logic [1:0]                         tb_dir_o
);
  import lsa_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEN+1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);

  logic [7:0]              sym_q;
  lsa_ctl_t                ctl_q;
  logic [LEN_W-1:0]        col_q;
  logic [7:0]              b_q;
  logic signed [SW-1:0]    h_q, diag_q, best_q;
  logic [LEN_W-1:0]        best_col_q;
  logic [1:0]              dir_q;
  logic [1:0]              tr_mem [MAX_LEN];

  logic signed [SW-1:0]    sub, gap_x, diag, left, m, d, ins, hmax, h;
  logic [1:0]              dir;
  logic [LEN_W-1:0]        col_m1;

  always_comb begin
    sub   = (sym_q == b_i) ? SW'({1'b0, match_gain_i})
                           : {{(SW-5){mismatch_gain_i[4]}}, mismatch_gain_i};
    gap_x = {{(SW-5){gap_gain_i[4]}}, gap_gain_i};
    diag  = ctl_i.first ? '0 : diag_q;
    left  = ctl_i.first ? '0 : h_q;
    m     = diag + sub;
    d     = h_i + gap_x;
    ins   = left + gap_x;
    if (m > d) begin
      hmax = (m > ins) ? m : ins;
    end else begin
      hmax = (d > ins) ? d : ins;
    end
    h = (hmax < 0) ? '0 : hmax;
    priority if (h == '0) dir = DIR_ZERO;
    else if (h == m)      dir = DIR_DIAG;
    else if (h == d)      dir = DIR_UP;
    else                  dir = DIR_LEFT;
    col_m1 = col_i - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_i;
    b_q   <= b_i;
    if (ld_en_i && ld_idx_i == IDX_W'(CELL_IDX)) sym_q <= ld_sym_i;
    if (ctl_i.v) begin
      h_q    <= h;
      diag_q <= h_i;
      tr_mem[col_m1[IDX_W-1:0]] <= dir;
    end
    if (clr_best_i) begin
      best_q     <= '0;
      best_col_q <= '0;
    end else if (ctl_i.v && h > best_q) begin
      best_q     <= h;
      best_col_q <= col_i;
    end
    dir_q <= tr_mem[tb_addr_i];
  end

  assign ctl_o      = ctl_q;
  assign col_o      = col_q;
  assign b_o        = b_q;
  assign h_o        = h_q;
  assign best_o     = best_q;
  assign best_col_o = best_col_q;
  assign tb_dir_o   = dir_q;

endmodule

// File: rtl/local_sequence_alignment_unit.sv
// A column read presents its item in the cycle after it is accepted.
// The final second-sequence load starts a run that streams the columns through
// the cell chain, scans the row maxima and walks the traceback in read and
// write steps, then presents the summary. Loads and reads run one item per cycle
// while no run is active and no pending output item is held.
// Reset clears control state and gain registers; symbol, trace and output data stores are not cleared.
// ----------------------------------------------------------------------------
// local_sequence_alignment_unit
// Smith-Waterman local alignment, linear gap, on a chain of row cells.
// ----------------------------------------------------------------------------
`include "local_sequence_alignment_unit_macros.svh"

module local_sequence_alignment_unit #(
  parameter int unsigned MAX_LEN = lsa_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // symbol[7:0]
  input  logic                       s_tlast,
  input  logic [1:0]                 s_tuser,   // func[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // score[11:0] end_row[20:12] end_col[29:21] gap_count[39:30]
  // align_length[49:40] column_a[57:50] column_b[65:58] overflow[66] zero[71:67]
  output logic [lsa_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast,   // final_column
  output logic                       m_tuser,   // result_kind
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lsa_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN+1);
  localparam int unsigned IDX_W  = $clog2(MAX_LEN);
  localparam int unsigned AL_W   = $clog2(2*MAX_LEN+1);
  localparam int unsigned AIDX_W = $clog2(2*MAX_LEN);
  localparam int unsigned SW     = $clog2(30*MAX_LEN+1) + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FEED, ST_DRAIN, ST_SCAN, ST_TB_RD, ST_TB_WR, ST_SUM
  } state_e;

  state_e              state_q, state_d;
  logic [3:0]          match_q;
  logic [4:0]          mism_q, gap_q;
  logic [LEN_W-1:0]    fl_q, fl_d, sl_q, sl_d;
  logic                ovf_q, ovf_d, done_q, done_d;
  logic [AL_W-1:0]     rptr_q, rptr_d, alen_q, alen_d, gaps_q, gaps_d;
  logic [SW-1:0]       best_q, best_d;
  logic [LEN_W-1:0]    bi_q, bi_d, bj_q, bj_d, ti_q, ti_d, tj_q, tj_d;
  logic [LEN_W:0]      cnt_q, cnt_d;
  logic                mv_q, mv_d, ml_q, ml_d, mu_q, mu_d;
  logic [OUT_W-1:0]    md_q, md_d;
  lsa_ctl_t            fctl_q, fctl_d;
  logic [LEN_W-1:0]    fcol_q, fcol_d;

  logic [7:0]          fs_mem [MAX_LEN];
  logic [7:0]          ss_mem [MAX_LEN];
  logic [15:0]         al_mem [2*MAX_LEN];
  logic [7:0]          fs_rd_q, ss_rd_q;
  logic [15:0]         al_rd_q;

  logic                in_acc, cfg_wr;
  logic                fs_we, ss_we, al_we, clr_best;
  logic [IDX_W-1:0]    fs_wa, ss_wa, fs_ra, ss_ra, tb_addr;
  logic [AIDX_W-1:0]   al_wa;
  logic [15:0]         al_wd;
  logic [7:0]          col_a, col_b;

  lsa_ctl_t            ctl_w  [MAX_LEN+1];
  logic [LEN_W-1:0]    col_w  [MAX_LEN+1];
  logic [7:0]          b_w    [MAX_LEN+1];
  logic signed [SW-1:0] h_w   [MAX_LEN+1];
  logic [SW-1:0]       cbest  [MAX_LEN];
  logic [LEN_W-1:0]    cbcol  [MAX_LEN];
  logic [1:0]          cdir   [MAX_LEN];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= MATCH_RST;
      mism_q  <= MISMATCH_RST;
      gap_q   <= GAP_RST;
    end else if (cfg_wr) begin
      if (paddr == REG_MATCH)    match_q <= pwdata[3:0];
      if (paddr == REG_MISMATCH) mism_q  <= pwdata[4:0];
      if (paddr == REG_GAP)      gap_q   <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MATCH)    prdata = {28'd0, match_q};
    if (paddr == REG_MISMATCH) prdata = {27'd0, mism_q};
    if (paddr == REG_GAP)      prdata = {27'd0, gap_q};
  end

  // ---------------- cell chain ----------------
  assign ctl_w[0] = fctl_q;
  assign col_w[0] = fcol_q;
  assign b_w[0]   = ss_rd_q;
  assign h_w[0]   = '0;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lsa_cell #(.MAX_LEN(MAX_LEN), .CELL_IDX(g), .SW(SW)) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .match_gain_i    (match_q),
      .mismatch_gain_i (mism_q),
      .gap_gain_i      (gap_q),
      .ld_en_i         (fs_we),
      .ld_idx_i        (fs_wa),
      .ld_sym_i        (s_tdata),
      .ctl_i           (ctl_w[g]),
      .col_i           (col_w[g]),
      .b_i             (b_w[g]),
      .h_i             (h_w[g]),
      .ctl_o           (ctl_w[g+1]),
      .col_o           (col_w[g+1]),
      .b_o             (b_w[g+1]),
      .h_o             (h_w[g+1]),
      .clr_best_i      (clr_best),
      .best_o          (cbest[g]),
      .best_col_o      (cbcol[g]),
      .tb_addr_i       (tb_addr),
      .tb_dir_o        (cdir[g])
    );
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_wa] <= s_tdata;
    if (ss_we) ss_mem[ss_wa] <= s_tdata;
    if (al_we) al_mem[al_wa] <= al_wd;
    fs_rd_q <= fs_mem[fs_ra];
    ss_rd_q <= ss_mem[ss_ra];
    al_rd_q <= al_mem[rptr_d[AIDX_W-1:0]];
  end

  // ---------------- control ----------------
  assign s_tready = (state_q == ST_IDLE) && (!mv_q || m_tready);
  assign in_acc   = s_tvalid && s_tready;

  always_comb begin
    logic [LEN_W-1:0] fl_eff, sl_eff, im1, jm1, cnt_l;
    logic [31:0]      w_best, w_bi, w_bj, w_gaps, w_alen;
    logic [AL_W-1:0]  rptr_p1;

    state_d  = state_q;
    fl_d     = fl_q;
    sl_d     = sl_q;
    ovf_d    = ovf_q;
    done_d   = done_q;
    rptr_d   = rptr_q;
    alen_d   = alen_q;
    gaps_d   = gaps_q;
    best_d   = best_q;
    bi_d     = bi_q;
    bj_d     = bj_q;
    ti_d     = ti_q;
    tj_d     = tj_q;
    cnt_d    = cnt_q;
    mv_d     = mv_q && !m_tready;
    md_d     = md_q;
    ml_d     = ml_q;
    mu_d     = mu_q;
    fctl_d   = '0;
    fcol_d   = fcol_q;
    fs_we    = 1'b0;
    ss_we    = 1'b0;
    al_we    = 1'b0;
    clr_best = 1'b0;
    fs_ra    = '0;
    ss_ra    = '0;
    tb_addr  = '0;
    col_a    = '0;
    col_b    = '0;
    fl_eff   = done_q ? '0 : fl_q;
    sl_eff   = done_q ? '0 : sl_q;
    im1      = ti_q - 1'b1;
    jm1      = tj_q - 1'b1;
    cnt_l    = cnt_q[LEN_W-1:0];
    fs_wa    = fl_eff[IDX_W-1:0];
    ss_wa    = sl_eff[IDX_W-1:0];
    al_wa    = alen_q[AIDX_W-1:0];
    al_wd    = '0;
    w_best   = 32'(best_q);
    w_bi     = 32'(bi_q);
    w_bj     = 32'(bj_q);
    w_gaps   = 32'(gaps_q);
    w_alen   = 32'(alen_q);
    rptr_p1  = rptr_q + 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_tuser == FUNC_LOAD_A || s_tuser == FUNC_LOAD_B)) begin
          // first load after a run starts fresh sequences
          fl_d   = fl_eff;
          sl_d   = sl_eff;
          ovf_d  = done_q ? 1'b0 : ovf_q;
          done_d = 1'b0;
          if (s_tuser == FUNC_LOAD_A) begin
            if (32'(fl_eff) < 32'(MAX_LEN)) begin
              fs_we = 1'b1;
              fl_d  = fl_eff + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            if (32'(sl_eff) < 32'(MAX_LEN)) begin
              ss_we = 1'b1;
              sl_d  = sl_eff + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            if (s_tlast) begin
              state_d  = ST_FEED;
              cnt_d    = '0;
              clr_best = 1'b1;
              done_d   = 1'b1;
              rptr_d   = '0;
            end
          end
        end else if (in_acc && s_tuser == FUNC_READ) begin
          mv_d = 1'b1;
          mu_d = KIND_COL;
          if (rptr_q < alen_q) begin
            col_a  = al_rd_q[15:8];
            col_b  = al_rd_q[7:0];
            ml_d   = (rptr_p1 == alen_q);
            rptr_d = rptr_p1;
          end else begin
            ml_d = 1'b1;
          end
          md_d = {5'd0, ovf_q, col_b, col_a, 50'd0};
        end
      end
      ST_FEED: begin
        // stream second-sequence symbols into the chain, one column a cycle
        if (cnt_l < sl_q && !cnt_q[LEN_W]) begin
          ss_ra        = cnt_l[IDX_W-1:0];
          fctl_d.v     = 1'b1;
          fctl_d.first = (cnt_q == '0);
          fcol_d       = cnt_l + 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end else begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (cnt_q == {1'b0, fl_q} + (LEN_W+1)'(2)) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          best_d  = '0;
          bi_d    = '0;
          bj_d    = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCAN: begin
        // row maxima in row order, strict compare keeps the earliest
        if (cnt_l < fl_q && !cnt_q[LEN_W]) begin
          if (cbest[cnt_l[IDX_W-1:0]] > best_q) begin
            best_d = cbest[cnt_l[IDX_W-1:0]];
            bi_d   = cnt_l + 1'b1;
            bj_d   = cbcol[cnt_l[IDX_W-1:0]];
          end
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = ST_TB_RD;
          ti_d    = bi_q;
          tj_d    = bj_q;
          gaps_d  = '0;
          alen_d  = '0;
        end
      end
      ST_TB_RD: begin
        if (ti_q == '0 || tj_q == '0 || 32'(alen_q) == 32'(2*MAX_LEN)) begin
          state_d = ST_SUM;
        end else begin
          fs_ra   = im1[IDX_W-1:0];
          ss_ra   = jm1[IDX_W-1:0];
          tb_addr = jm1[IDX_W-1:0];
          state_d = ST_TB_WR;
        end
      end
      ST_TB_WR: begin
        state_d = ST_TB_RD;
        unique case (cdir[im1[IDX_W-1:0]])
          DIR_ZERO: state_d = ST_SUM;
          DIR_DIAG: begin
            al_wd = {fs_rd_q, ss_rd_q};
            ti_d  = im1;
            tj_d  = jm1;
          end
          DIR_UP: begin
            al_wd  = {fs_rd_q, GAP_SYM};
            gaps_d = gaps_q + 1'b1;
            ti_d   = im1;
          end
          DIR_LEFT: begin
            al_wd  = {GAP_SYM, ss_rd_q};
            gaps_d = gaps_q + 1'b1;
            tj_d   = jm1;
          end
          default: state_d = ST_SUM;
        endcase
        if (cdir[im1[IDX_W-1:0]] != DIR_ZERO) begin
          al_we  = 1'b1;
          alen_d = alen_q + 1'b1;
        end
      end
      ST_SUM: begin
        mv_d    = 1'b1;
        mu_d    = KIND_SUM;
        ml_d    = 1'b0;
        md_d    = {5'd0, ovf_q, 16'd0, w_alen[9:0], w_gaps[9:0], w_bj[8:0], w_bi[8:0],
                   (w_best > 32'd4095) ? 12'hFFF : w_best[11:0]};
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fl_q    <= '0;
      sl_q    <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
      rptr_q  <= '0;
      alen_q  <= '0;
      gaps_q  <= '0;
      best_q  <= '0;
      bi_q    <= '0;
      bj_q    <= '0;
      ti_q    <= '0;
      tj_q    <= '0;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
      fctl_q  <= '0;
    end else begin
      state_q <= state_d;
      fl_q    <= fl_d;
      sl_q    <= sl_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
      rptr_q  <= rptr_d;
      alen_q  <= alen_d;
      gaps_q  <= gaps_d;
      best_q  <= best_d;
      bi_q    <= bi_d;
      bj_q    <= bj_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      fctl_q  <= fctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    md_q   <= md_d;
    ml_q   <= ml_d;
    mu_q   <= mu_d;
    fcol_q <= fcol_d;
  end

  assign m_tvalid = mv_q;
  assign m_tdata  = md_q;
  assign m_tlast  = ml_q;
  assign m_tuser  = mu_q;

  `LSA_ASSERT_IMP(a_busy_stalls, clk_i, rst_ni, state_q != ST_IDLE, !s_tready,
    "input accepted while a run is active")
  `LSA_ASSERT_IMP(a_sum_out_free, clk_i, rst_ni, state_q == ST_SUM, !m_tvalid,
    "summary would overwrite a pending item")
  `LSA_ASSERT_NXT(a_sum_kind, clk_i, rst_ni, state_q == ST_SUM,
    m_tvalid && m_tuser == KIND_SUM, "summary not presented after run")
  `LSA_ASSERT_IMP(a_tb_inside, clk_i, rst_ni, state_q == ST_TB_WR,
    ti_q != '0 && tj_q != '0, "traceback step outside the matrix")
  `LSA_ASSERT_IMP(a_rptr_bound, clk_i, rst_ni, state_q == ST_IDLE, rptr_q <= alen_q,
    "read pointer beyond stored alignment")

endmodule

// File: tb/sv/tb_local_sequence_alignment_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Local sequence alignment unit testbench
// Loads symbol pairs over the input stream and checks each alignment summary
// and each column read against a scoring model kept in the testbench.
// Gains are changed over the APB port between runs.
// ----------------------------------------------------------------------------
module tb_local_sequence_alignment_unit;
  import lsa_pkg::*;

  localparam int MAXL = 256;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [11:0] score;
    logic [8:0] row;
    logic [8:0] col;
    logic [9:0] gaps;
    logic [9:0] len;
    logic [7:0] col_a;
    logic [7:0] col_b;
    logic       fin;
    logic       ovf;
  } align_res_t;

  // Smith-Waterman model and store of pending results
  class align_scoreboard;
    int          match_w, mism_w, gap_w;
    logic [7:0]  seq_a[MAXL], seq_b[MAXL];
    int          len_a, len_b;
    logic [15:0] cols[2*MAXL];
    int          n_cols, n_gaps, top, top_i, top_j, rd;
    bit          ovf, done;
    align_res_t  pending[$];
    int          errors;

    function new();
      match_w = 1; mism_w = -1; gap_w = -1;
      len_a = 0; len_b = 0; n_cols = 0; rd = 0; ovf = 0; done = 0; errors = 0;
    endfunction

    function void align();
      int h[MAXL+1][MAXL+1];
      logic [1:0] dir[MAXL+1][MAXL+1];
      int i, j, m, d, l, v;
      top = 0; top_i = 0; top_j = 0; n_gaps = 0; n_cols = 0; rd = 0;
      for (j = 0; j <= len_b; j++) h[0][j] = 0;
      for (i = 1; i <= len_a; i++) begin
        h[i][0] = 0;
        for (j = 1; j <= len_b; j++) begin
          m = h[i-1][j-1] + ((seq_a[i-1] == seq_b[j-1]) ? match_w : mism_w);
          d = h[i-1][j] + gap_w;
          l = h[i][j-1] + gap_w;
          v = m; if (d > v) v = d; if (l > v) v = l;
          if (v < 0) v = 0;
          if (v == 0) dir[i][j] = DIR_ZERO;
          else if (v == m) dir[i][j] = DIR_DIAG;
          else if (v == d) dir[i][j] = DIR_UP;
          else dir[i][j] = DIR_LEFT;
          h[i][j] = v;
          if (v > top) begin top = v; top_i = i; top_j = j; end
        end
      end
      i = top_i; j = top_j;
      while (i > 0 && j > 0 && n_cols < 2*MAXL && dir[i][j] != DIR_ZERO) begin
        if (dir[i][j] == DIR_DIAG) begin
          cols[n_cols] = {seq_a[i-1], seq_b[j-1]}; i--; j--;
        end else if (dir[i][j] == DIR_UP) begin
          cols[n_cols] = {seq_a[i-1], GAP_SYM}; n_gaps++; i--;
        end else begin
          cols[n_cols] = {GAP_SYM, seq_b[j-1]}; n_gaps++; j--;
        end
        n_cols++;
      end
    endfunction

    function void note_item(logic [1:0] fn, logic [7:0] sym, logic lst);
      align_res_t r;
      r = '0;
      if (fn == FUNC_LOAD_A || fn == FUNC_LOAD_B) begin
        if (done) begin len_a = 0; len_b = 0; ovf = 0; done = 0; end
        if (fn == FUNC_LOAD_A) begin
          if (len_a < MAXL) seq_a[len_a++] = sym; else ovf = 1;
        end else begin
          if (len_b < MAXL) seq_b[len_b++] = sym; else ovf = 1;
          if (lst) begin
            align();
            done = 1;
            r.kind = KIND_SUM;
            r.score = (top > 4095) ? 12'd4095 : top[11:0];
            r.row = top_i[8:0]; r.col = top_j[8:0];
            r.gaps = n_gaps[9:0]; r.len = n_cols[9:0]; r.ovf = ovf;
            pending.push_back(r);
          end
        end
      end else if (fn == FUNC_READ) begin
        r.kind = KIND_COL; r.ovf = ovf;
        if (rd < n_cols) begin
          {r.col_a, r.col_b} = cols[rd];
          r.fin = (rd + 1 == n_cols);
          rd++;
        end else r.fin = 1;
        pending.push_back(r);
      end
    endfunction

    function void check_result(align_res_t got);
      align_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: exp %h got %h", exp_r, got);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_tvalid = 0, s_tlast = 0, m_tready = 0;
  logic [7:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic s_tready, m_tvalid, m_tlast, m_tuser, pready;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  align_scoreboard sb = new();
  int idle_cycles = 0;
  int out_wait = 0;
  localparam int WDOG = 400000;

  always #1 clk_i = ~clk_i;

  local_sequence_alignment_unit u_dut (.*);

  // result side: random wait per item, check on accept
  always @(posedge clk_i) begin
    align_res_t got;
    int w;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser; got.score = m_tdata[11:0]; got.row = m_tdata[20:12];
        got.col = m_tdata[29:21]; got.gaps = m_tdata[39:30]; got.len = m_tdata[49:40];
        got.col_a = m_tdata[57:50]; got.col_b = m_tdata[65:58]; got.fin = m_tlast;
        got.ovf = m_tdata[66];
        sb.check_result(got);
        w = $urandom_range(0, 5);
        out_wait <= w;
        m_tready <= (w == 0);
      end else if (out_wait > 1) begin
        out_wait <= out_wait - 1;
      end else begin
        out_wait <= 0;
        m_tready <= 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] fn, logic [7:0] sym, logic lst, bit no_gap = 0);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk_i);
    end
    s_tvalid <= 1; s_tuser <= fn; s_tdata <= sym; s_tlast <= lst;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_item(fn, sym, lst);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_gains(int m, int mm, int g);
    reg_write(REG_MATCH, m);    sb.match_w = m;
    reg_write(REG_MISMATCH, mm & 5'h1F); sb.mism_w = mm;
    reg_write(REG_GAP, g & 5'h1F);       sb.gap_w = g;
  endtask

  // one load pass plus column reads; alpha bounds the symbols, small values give real matches
  task automatic run_job(int na, int nb, int alpha, int reads, bit tight);
    for (int k = 0; k < na; k++)
      send_item(FUNC_LOAD_A, 8'($urandom_range(0, alpha)), k == na-1, tight);
    for (int k = 0; k < nb; k++)
      send_item(FUNC_LOAD_B, 8'($urandom_range(0, alpha)), k == nb-1, tight);
    for (int k = 0; k < reads; k++) send_item(FUNC_READ, 0, 0, tight);
  endtask

  initial begin
    int na, nb;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty run, extremes, ignored selector, read past end
    send_item(FUNC_LOAD_B, 8'hFF, 1);
    send_item(FUNC_READ, 0, 0);
    send_item(FUNC_RSVD, 8'hAA, 1);
    send_item(FUNC_LOAD_A, 8'h00, 0);
    send_item(FUNC_LOAD_A, 8'hFF, 1);
    send_item(FUNC_LOAD_A, 8'h2D, 0);
    send_item(FUNC_LOAD_B, 8'hFF, 0);
    send_item(FUNC_LOAD_B, 8'h00, 0);
    send_item(FUNC_LOAD_B, 8'h2D, 1);
    repeat (5) send_item(FUNC_READ, 8'h55, 1);
    drain();
    set_gains(15, 0, 0);
    run_job(6, 5, 1, 12, 0);
    drain();
    set_gains(0, -15, -15);
    run_job(4, 4, 2, 3, 0);
    drain();
    // overflow on both sequences, dropped final symbol still starts the run
    set_gains(15, -15, -15);
    run_job(MAXL + 2, MAXL + 1, 255, 4, 1);
    drain();
    set_gains(2, -1, -2);
    // random jobs
    while (sb.len_a >= 0) begin
      static int sent = 0;
      if (sent > 1280) break;
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
      if (nb == 0) nb = 1;
      if ($urandom_range(0, 9) == 0) send_item(FUNC_RSVD, 8'($urandom), $urandom_range(0, 1));
      run_job(na, nb, $urandom_range(1, 255), $urandom_range(0, 20), $urandom_range(0, 3) == 0);
      sent += na + nb + 10;
      if ($urandom_range(0, 7) == 0) begin
        drain();
        set_gains($urandom_range(0, 15), -$urandom_range(0, 15), -$urandom_range(0, 15));
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/lsa_pkg.sv
rtl/lsa_cell.sv
rtl/local_sequence_alignment_unit.sv
tb/sv/tb_local_sequence_alignment_unit.sv
